// File: hdl/b64dec_pkg.sv
// Shared types, constants and the alphabet lookup for the Base64 decoder.
// No dependencies; every other file but the interfaces refers to this package.
package b64dec_pkg;

  // Result codes carried in the status field of each result item.
  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_INVALID = 2'd1,
    ST_PADDING = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  // One character classified against the standard alphabet.
  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] value;
  } sextet_t;

  // One result item as it sits in the result buffer.
  typedef struct packed {
    logic [7:0] byte_out;
    status_t    status;
    logic       last_in_group;
    logic       stream_end;
  } result_t;

  localparam int MAX_RES   = 3;
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  // Results released by one decoded character, first result in slot 0.
  typedef struct packed {
    logic [1:0]              count;
    result_t [MAX_RES-1:0]   res;
  } push_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s = '{bad: 1'b0, pad: 1'b0, value: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else if (c == 8'h3D) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// File: hdl/b64dec_if.sv
// Handshake interfaces for the character input and the result output.
// Depends on nothing; the payload matches the decoder's item fields.
interface b64_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface b64_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] status;
  logic       last_in_group;
  logic       stream_end;

  modport source (output valid, output byte_out, output status, output last_in_group,
                  output stream_end, input ready);
  modport sink   (input valid, input byte_out, input status, input last_in_group,
                  input stream_end, output ready);
endinterface

// File: hdl/b64dec_decode.sv
// Input register, group state and per-character decode for the Base64 decoder.
// Depends on b64dec_pkg and b64_char_if; pushes results toward b64dec_result_fifo.
module b64dec_decode (
  input  logic                  clk,
  input  logic                  rst,
  b64_char_if.sink              chars,
  input  logic [b64dec_pkg::CNT_W-1:0] free,
  output b64dec_pkg::push_t     push
);

  logic        stg_valid;
  logic [7:0]  stg_char;
  logic        stg_eot;

  logic [17:0] sextet_buffer, sextet_buffer_next;
  logic [1:0]  group_position, group_position_next;
  logic        third_was_pad, third_was_pad_next;
  logic        error_discard, error_discard_next;

  b64dec_pkg::sextet_t sx;
  b64dec_pkg::push_t   res;
  logic [23:0]         word;
  logic [5:0]          s_val;
  logic                fire;

  assign sx = b64dec_pkg::sextet_of(stg_char);

  always_comb begin
    sextet_buffer_next  = sextet_buffer;
    group_position_next = group_position;
    third_was_pad_next  = third_was_pad;
    error_discard_next  = error_discard;
    res                 = '0;
    word                = '0;
    s_val               = sx.value;

    if (error_discard) begin
      if (stg_eot) begin
        sextet_buffer_next  = '0;
        group_position_next = '0;
        third_was_pad_next  = 1'b0;
        error_discard_next  = 1'b0;
      end
    end else if (sx.bad || (group_position < 2'd2 && sx.pad) ||
                 (group_position == 2'd3 && third_was_pad && !sx.pad)) begin
      // Any error clears the group and discards input until end of text.
      sextet_buffer_next        = '0;
      group_position_next       = '0;
      third_was_pad_next        = 1'b0;
      error_discard_next        = !stg_eot;
      res.count                 = 2'd1;
      res.res[0].status         = sx.bad ? b64dec_pkg::ST_INVALID : b64dec_pkg::ST_PADDING;
      res.res[0].last_in_group  = 1'b1;
      res.res[0].stream_end     = stg_eot;
    end else if (group_position != 2'd3) begin
      if (sx.pad) begin
        third_was_pad_next = 1'b1;
        s_val              = 6'd0;
      end
      sextet_buffer_next  = {sextet_buffer[11:0], s_val};
      group_position_next = group_position + 2'd1;
      if (stg_eot) begin
        // Text ends inside a group: report it and drop the partial group.
        sextet_buffer_next       = '0;
        group_position_next      = '0;
        third_was_pad_next       = 1'b0;
        res.count                = 2'd1;
        res.res[0].status        = b64dec_pkg::ST_TRUNC;
        res.res[0].last_in_group = 1'b1;
        res.res[0].stream_end    = 1'b1;
      end
    end else begin
      sextet_buffer_next  = '0;
      group_position_next = '0;
      third_was_pad_next  = 1'b0;
      if (third_was_pad) begin
        res.count = 2'd1;
      end else if (sx.pad) begin
        res.count = 2'd2;
      end else begin
        res.count = 2'd3;
      end
      word = {sextet_buffer, (res.count == 2'd3) ? sx.value : 6'd0};
      res.res[0].byte_out = word[23:16];
      res.res[1].byte_out = word[15:8];
      res.res[2].byte_out = word[7:0];
      res.res[0].status   = b64dec_pkg::ST_DATA;
      res.res[1].status   = b64dec_pkg::ST_DATA;
      res.res[2].status   = b64dec_pkg::ST_DATA;
      unique case (res.count)
        2'd1: begin
          res.res[0].last_in_group = 1'b1;
          res.res[0].stream_end    = stg_eot;
        end
        2'd2: begin
          res.res[1].last_in_group = 1'b1;
          res.res[1].stream_end    = stg_eot;
        end
        default: begin
          res.res[2].last_in_group = 1'b1;
          res.res[2].stream_end    = stg_eot;
        end
      endcase
    end
  end

  // The held character moves on only when the buffer has room for all its results.
  assign fire        = stg_valid && ({1'b0, res.count} <= free);
  assign chars.ready = !stg_valid || fire;

  always_comb begin
    push = res;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid      <= 1'b0;
      sextet_buffer  <= '0;
      group_position <= '0;
      third_was_pad  <= 1'b0;
      error_discard  <= 1'b0;
    end else begin
      if (chars.ready) begin
        stg_valid <= chars.valid;
      end
      if (fire) begin
        sextet_buffer  <= sextet_buffer_next;
        group_position <= group_position_next;
        third_was_pad  <= third_was_pad_next;
        error_discard  <= error_discard_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      stg_char <= chars.char_in;
      stg_eot  <= chars.end_of_text;
    end
  end

endmodule

// File: hdl/b64dec_result_fifo.sv
// Small result buffer: takes up to three results per cycle, gives one per cycle when ready.
// Depends on b64dec_pkg and b64_byte_if.
module b64dec_result_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  b64dec_pkg::push_t            push,
  output logic [b64dec_pkg::CNT_W-1:0] free,
  b64_byte_if.source                   bytes
);

  b64dec_pkg::result_t mem [b64dec_pkg::RES_DEPTH];

  logic [b64dec_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [b64dec_pkg::CNT_W-1:0] count;
  logic                         pop;
  b64dec_pkg::result_t          head;

  assign pop  = (count != '0) && bytes.ready;
  assign free = b64dec_pkg::CNT_W'(b64dec_pkg::RES_DEPTH) - count;
  assign head = mem[rd_ptr];

  assign bytes.valid         = (count != '0);
  assign bytes.byte_out      = head.byte_out;
  assign bytes.status        = head.status;
  assign bytes.last_in_group = head.last_in_group;
  assign bytes.stream_end    = head.stream_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + b64dec_pkg::PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + b64dec_pkg::CNT_W'(push.count) - b64dec_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < b64dec_pkg::MAX_RES; i++) begin
      if (b64dec_pkg::CNT_W'(i) < b64dec_pkg::CNT_W'(push.count)) begin
        mem[wr_ptr + b64dec_pkg::PTR_W'(i)] <= push.res[i];
      end
    end
  end

endmodule

// File: hdl/base64_decoder.sv
// Top level of the streaming Base64 decoder (standard alphabet, '=' padding).
// Depends on b64dec_pkg, the interfaces, b64dec_decode and b64dec_result_fifo.
//
// Usage:
// The chars channel takes one encoded ASCII character per item, with end_of_text
// set on the last character of the text. The bytes channel returns result items:
// decoded data bytes (status 0) or a single error item (invalid character,
// misplaced padding, truncated final group). The fourth character of a group
// releases one to three data bytes; the other characters release nothing unless
// they end the text or are in error. After an error the block drops characters
// silently until the one that carries end_of_text, which restarts decoding.
//
// An accepted character is held in the input register and decoded from it; its
// results enter the result buffer together once they all fit and are offered
// from there; further results of the same character follow one per cycle while
// the receiver takes them.
// Throughput: one character per cycle sustained while the receiver takes every
// result, set by the four-entry result buffer that absorbs the three bytes of
// each group while the next characters of the following group are taken.
// Reset clears the group state, the error flag and the result buffer. When the
// receiver stalls, results wait in the buffer; once the buffer cannot hold the
// results of the waiting character, chars.ready falls and input stops.
module base64_decoder (
  input  logic       clk,
  input  logic       rst,
  b64_char_if.sink   chars,
  b64_byte_if.source bytes
);

  b64dec_pkg::push_t            push;
  logic [b64dec_pkg::CNT_W-1:0] free;

  // Character decode and group state; results go out only when they all fit.
  b64dec_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .free  (free),
    .push  (push)
  );

  // Result buffer, which also serves as the registered output stage.
  b64dec_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .free  (free),
    .bytes (bytes)
  );

endmodule

// File: hdl/b64dec_checker.sv
// Port-level assertions for base64_decoder, attached by the bind below.
// Depends on the top level's ports and on b64dec_pkg for the status codes.
module b64dec_props (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_out,
  input logic [1:0] status,
  input logic       last_in_group,
  input logic       stream_end
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status) &&
      $stable(last_in_group) && $stable(stream_end))
    else $error("result changed or vanished while stalled");

  // An error is always the only result of its character.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != b64dec_pkg::ST_DATA) |-> last_in_group)
    else $error("error result not marked last in group");

  // The close of the text is the last result of its character.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> last_in_group)
    else $error("stream end on a result that is not last in group");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind base64_decoder b64dec_props u_b64dec_props (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (bytes.valid),
  .out_ready     (bytes.ready),
  .byte_out      (bytes.byte_out),
  .status        (bytes.status),
  .last_in_group (bytes.last_in_group),
  .stream_end    (bytes.stream_end)
);
